>>> hdl/ffsa_pkg.sv
// Shared codes and the control bundle of the first-fit segment allocator.
package ffsa_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam int REQ_W  = 11;
    localparam int ADDR_W = 10;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              search;
        logic              update;
        logic              split;
        logic              alloc;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
    } ffsa_ctl_t;

endpackage

>>> hdl/first_fit_segment_allocator_top.sv
// Top level: request sequencer, first-match pick and the row of segment cells.
// Requests are registered on acceptance, match flags in the search state, the result and its done
// strobe in the update state. A new request can be accepted in the update state; the registered
// match flags of the cell row sit between the search cycle and the pick/shift-insert cycle.
// Reset (async, active low) leaves one free segment spanning the whole memory, usable at once.
// Results are shown for one cycle only; the receiver cannot stall them.
module first_fit_segment_allocator_top #(
    parameter int MEM_SIZE     = 1024,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        cmd,
    input  logic [10:0] req_size,
    input  logic [9:0]  free_addr,
    output logic        busy,
    output logic        done,
    output logic [2:0]  status,
    output logic [9:0]  alloc_addr
);

    localparam int AW  = $clog2(MEM_SIZE);
    localparam int SW  = $clog2(MEM_SIZE + 1);
    localparam int N   = MAX_SEGMENTS;
    localparam int CW  = (SW > ffsa_pkg::REQ_W) ? SW : ffsa_pkg::REQ_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        op_reg;
    logic [10:0] req_reg;
    logic [9:0]  addr_reg;
    logic        done_reg;
    logic [2:0]  status_reg, status_next;
    logic [9:0]  aaddr_reg, aaddr_next;
    logic        accept;

    ffsa_pkg::ffsa_ctl_t ctl;

    logic [AW-1:0] start_arr [N];
    logic [SW-1:0] size_arr  [N];
    logic [N-1:0]  alloc_vec, valid_vec, hit_vec, exact_vec;
    logic [N-1:0]  onehot, above;
    logic [AW-1:0] start_sel;
    logic          any_hit, exact_sel, full, bad_size, ok;

    assign accept = start && !busy;
    assign busy   = (state_reg == S_SRCH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_SRCH;
            S_SRCH:  state_next = S_UPD;
            S_UPD:   state_next = accept ? S_SRCH : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // first match: lowest set bit, and the cells above it
    always_comb
    begin
        onehot  = hit_vec & (~hit_vec + N'(1));
        above   = ~(hit_vec ^ (hit_vec - N'(1)));
        any_hit = |hit_vec;
        exact_sel = |(onehot & exact_vec);
        full    = valid_vec[N-1];
        start_sel = '0;
        for (int i = 0; i < N; i++)
            if (onehot[i])
                start_sel = start_sel | start_arr[i];
    end

    always_comb
    begin
        bad_size    = (req_reg == 11'd0) || (CW'(req_reg) > CW'(MEM_SIZE));
        status_next = ffsa_pkg::ST_OK;
        aaddr_next  = '0;
        ok          = 1'b0;
        if (op_reg == ffsa_pkg::CMD_ALLOC)
        begin
            if (bad_size)
                status_next = ffsa_pkg::ST_BAD_SIZE;
            else if (!any_hit)
                status_next = ffsa_pkg::ST_NO_FIT;
            else if (!exact_sel && full)
                status_next = ffsa_pkg::ST_FULL;
            else
            begin
                ok         = 1'b1;
                aaddr_next = 10'(start_sel);
            end
        end
        else
        begin
            if (!any_hit)
                status_next = ffsa_pkg::ST_NOT_FOUND;
            else
                ok = 1'b1;
        end

        ctl.search = (state_reg == S_SRCH);
        ctl.update = (state_reg == S_UPD) && ok;
        ctl.split  = (op_reg == ffsa_pkg::CMD_ALLOC) && !exact_sel;
        ctl.alloc  = (op_reg == ffsa_pkg::CMD_ALLOC);
        ctl.req    = req_reg;
        ctl.addr   = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= ffsa_pkg::CMD_ALLOC;
            req_reg    <= '0;
            addr_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ffsa_pkg::ST_OK;
            aaddr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg   <= cmd;
                req_reg  <= req_size;
                addr_reg <= free_addr;
            end
            done_reg <= (state_reg == S_UPD);
            if (state_reg == S_UPD)
            begin
                status_reg <= status_next;
                aaddr_reg  <= aaddr_next;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic          l_sel, l_above, l_alloc, l_valid;
            logic [AW-1:0] l_start;
            logic [SW-1:0] l_size;

            if (g == 0)
            begin : g_head
                assign l_sel   = 1'b0;
                assign l_above = 1'b0;
                assign l_alloc = 1'b0;
                assign l_valid = 1'b0;
                assign l_start = '0;
                assign l_size  = '0;
            end
            else
            begin : g_link
                assign l_sel   = onehot[g-1];
                assign l_above = above[g-1];
                assign l_alloc = alloc_vec[g-1];
                assign l_valid = valid_vec[g-1];
                assign l_start = start_arr[g-1];
                assign l_size  = size_arr[g-1];
            end

            ffsa_cell #(
                .MEM_SIZE (MEM_SIZE),
                .AW       (AW),
                .SW       (SW),
                .HEAD     (g == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .sel        (onehot[g]),
                .left_sel   (l_sel),
                .left_above (l_above),
                .left_start (l_start),
                .left_size  (l_size),
                .left_alloc (l_alloc),
                .left_valid (l_valid),
                .seg_start  (start_arr[g]),
                .seg_size   (size_arr[g]),
                .seg_alloc  (alloc_vec[g]),
                .seg_valid  (valid_vec[g]),
                .hit        (hit_vec[g]),
                .exact      (exact_vec[g])
            );
        end
    endgenerate

    assign done       = done_reg;
    assign status     = status_reg;
    assign alloc_addr = aaddr_reg;

endmodule

>>> hdl/ffsa_cell.sv
// One segment cell: holds a table entry, flags a match, shifts or splits on update.
module ffsa_cell #(
    parameter int  MEM_SIZE = 1024,
    parameter int  AW       = 10,
    parameter int  SW       = 11,
    parameter bit  HEAD     = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffsa_pkg::ffsa_ctl_t ctl,
    input  logic               sel,
    input  logic               left_sel,
    input  logic               left_above,
    input  logic [AW-1:0]      left_start,
    input  logic [SW-1:0]      left_size,
    input  logic               left_alloc,
    input  logic               left_valid,
    output logic [AW-1:0]      seg_start,
    output logic [SW-1:0]      seg_size,
    output logic               seg_alloc,
    output logic               seg_valid,
    output logic               hit,
    output logic               exact
);

    localparam int XW0 = (SW > ffsa_pkg::REQ_W) ? SW : ffsa_pkg::REQ_W;
    localparam int XW  = (XW0 > ffsa_pkg::ADDR_W) ? XW0 : ffsa_pkg::ADDR_W;

    logic [AW-1:0] start_reg, start_next;
    logic [SW-1:0] size_reg, size_next;
    logic          alloc_reg, alloc_next;
    logic          valid_reg, valid_next;
    logic          hit_reg, exact_reg;

    logic [XW-1:0] req_x, addr_x, start_x, size_x, lstart_x, lsize_x;
    logic          hit_c, exact_c;

    always_comb
    begin
        req_x    = XW'(ctl.req);
        addr_x   = XW'(ctl.addr);
        start_x  = XW'(start_reg);
        size_x   = XW'(size_reg);
        lstart_x = XW'(left_start);
        lsize_x  = XW'(left_size);

        exact_c = (size_x == req_x);
        if (ctl.alloc)
            hit_c = valid_reg && !alloc_reg && (size_x >= req_x);
        else
            hit_c = valid_reg && (start_x == addr_x);

        start_next = start_reg;
        size_next  = size_reg;
        alloc_next = alloc_reg;
        valid_next = valid_reg;
        if (ctl.update)
        begin
            if (sel)
            begin
                alloc_next = ctl.alloc;
                if (ctl.split)
                    size_next = SW'(req_x);
            end
            else if (ctl.split && left_sel)
            begin
                // remainder of the split segment on the left
                start_next = AW'(lstart_x + req_x);
                size_next  = SW'(lsize_x - req_x);
                alloc_next = 1'b0;
                valid_next = 1'b1;
            end
            else if (ctl.split && left_above)
            begin
                start_next = left_start;
                size_next  = left_size;
                alloc_next = left_alloc;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            size_reg  <= HEAD ? SW'(MEM_SIZE) : '0;
            alloc_reg <= 1'b0;
            valid_reg <= HEAD;
            hit_reg   <= 1'b0;
            exact_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            size_reg  <= size_next;
            alloc_reg <= alloc_next;
            valid_reg <= valid_next;
            if (ctl.search)
            begin
                hit_reg   <= hit_c;
                exact_reg <= exact_c;
            end
        end
    end

    assign seg_start = start_reg;
    assign seg_size  = size_reg;
    assign seg_alloc = alloc_reg;
    assign seg_valid = valid_reg;
    assign hit       = hit_reg;
    assign exact     = exact_reg;

endmodule

>>> bench/alloc_result_check.sv
// Watches the allocator's request and result channels, predicts each answer and compares.
`timescale 1ns / 1ps

module alloc_result_check
    import ffsa_pkg::*;
#(
    parameter int MEM_SIZE     = 1024,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              cmd,
    input  logic [REQ_W-1:0]  req_size,
    input  logic [ADDR_W-1:0] free_addr,
    input  logic              done,
    input  logic [2:0]        status,
    input  logic [ADDR_W-1:0] alloc_addr,
    output int                mismatch_count,
    output int                outstanding
);

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] addr;
    } answer_t;

    // Shadow segment table; entries 0 .. seg_used-1 are live, in address order.
    logic [ADDR_W-1:0] seg_start [MAX_SEGMENTS];
    logic [REQ_W-1:0]  seg_size  [MAX_SEGMENTS];
    logic              seg_taken [MAX_SEGMENTS];
    int                seg_used;

    answer_t answers_due[$];

    function automatic answer_t allocate_segment(input logic [REQ_W-1:0] req);
        answer_t ans;
        int      hit;
        ans = '{status: ST_OK, addr: '0};
        hit = -1;
        if (req == 0 || req > MEM_SIZE)
        begin
            ans.status = ST_BAD_SIZE;
            return ans;
        end
        for (int i = 0; i < seg_used; i++)
            if (hit < 0 && !seg_taken[i] && seg_size[i] >= req)
                hit = i;
        if (hit < 0)
        begin
            ans.status = ST_NO_FIT;
            return ans;
        end
        if (seg_size[hit] != req)
        begin
            if (seg_used >= MAX_SEGMENTS)
            begin
                ans.status = ST_FULL;
                return ans;
            end
            for (int k = seg_used; k > hit + 1; k--)
            begin
                seg_start[k] = seg_start[k-1];
                seg_size[k]  = seg_size[k-1];
                seg_taken[k] = seg_taken[k-1];
            end
            seg_start[hit+1] = seg_start[hit] + req[ADDR_W-1:0];
            seg_size[hit+1]  = seg_size[hit] - req;
            seg_taken[hit+1] = 1'b0;
            seg_size[hit]    = req;
            seg_used++;
        end
        seg_taken[hit] = 1'b1;
        ans.addr = seg_start[hit];
        return ans;
    endfunction

    function automatic answer_t release_segment(input logic [ADDR_W-1:0] addr);
        answer_t ans;
        ans = '{status: ST_NOT_FOUND, addr: '0};
        for (int i = 0; i < seg_used; i++)
            if (ans.status == ST_NOT_FOUND && seg_start[i] == addr)
            begin
                seg_taken[i] = 1'b0;
                ans.status = ST_OK;
            end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                seg_start[i] = '0;
                seg_size[i]  = '0;
                seg_taken[i] = 1'b0;
            end
            seg_size[0] = REQ_W'(MEM_SIZE);
            seg_used = 1;
            answers_due.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result status=%0d addr=%0d",
                                 $realtime, status, alloc_addr);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.status !== status || want.addr !== alloc_addr)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch: expected status=%0d addr=%0d,",
                                      " got status=%0d addr=%0d"},
                                     $realtime, want.status, want.addr, status, alloc_addr);
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd == CMD_ALLOC)
                    answers_due.push_back(allocate_segment(req_size));
                else
                    answers_due.push_back(release_segment(free_addr));
            end
            outstanding = answers_due.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the allocator bench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import ffsa_pkg::*;

    localparam int RANDOM_ITEMS = 1750;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              cmd;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
    logic              busy;
    logic              done;
    logic [2:0]        status;
    logic [ADDR_W-1:0] alloc_addr;
    int                mismatch_count;
    int                outstanding;

    // Requests in flight, and segments seen granted; used to aim frees and exact fits.
    logic              inflight_cmd[$];
    logic [REQ_W-1:0]  inflight_size[$];
    logic [ADDR_W-1:0] granted_addr[$];
    logic [REQ_W-1:0]  granted_size[$];

    first_fit_segment_allocator_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .req_size   (req_size),
        .free_addr  (free_addr),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .alloc_addr (alloc_addr)
    );

    alloc_result_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .req_size       (req_size),
        .free_addr      (free_addr),
        .done           (done),
        .status         (status),
        .alloc_addr     (alloc_addr),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        logic             c;
        logic [REQ_W-1:0] sz;
        if (rst_n && done && inflight_cmd.size() != 0)
        begin
            c  = inflight_cmd.pop_front();
            sz = inflight_size.pop_front();
            if (c == CMD_ALLOC && status == ST_OK)
            begin
                if (granted_addr.size() >= 48)
                begin
                    granted_addr.delete(0);
                    granted_size.delete(0);
                end
                granted_addr.push_back(alloc_addr);
                granted_size.push_back(sz);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue(input logic c, input logic [REQ_W-1:0] sz,
                         input logic [ADDR_W-1:0] addr, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        req_size  <= sz;
        free_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        inflight_cmd.push_back(c);
        inflight_size.push_back(sz);
        @(negedge clk);
    endtask

    task automatic random_request(input int gap);
        int               roll;
        int               pick;
        logic [REQ_W-1:0] sz;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50 && granted_size.size() != 0)
                sz = granted_size[$urandom_range(0, granted_size.size() - 1)];
            else if (pick < 80)
                sz = REQ_W'($urandom_range(1, 64));
            else
                sz = REQ_W'($urandom_range(1, 1024));
            issue(CMD_ALLOC, sz, ADDR_W'($urandom), gap);
        end
        else if (roll < 90 && granted_addr.size() != 0)
            issue(CMD_FREE, REQ_W'($urandom),
                  granted_addr[$urandom_range(0, granted_addr.size() - 1)], gap);
        else if (roll < 95)
            issue(CMD_ALLOC, REQ_W'($urandom_range(0, 2047)), ADDR_W'($urandom), gap);
        else
            issue(CMD_FREE, REQ_W'($urandom), ADDR_W'($urandom_range(0, 1023)), gap);
    endtask

    initial
    begin
        int busy_phase;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_ALLOC;
        req_size  = '0;
        free_addr = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: size limits, unknown address, freeing a free segment, exact fits,
        // no fit, then split until the table fills.
        issue(CMD_ALLOC, 11'd0,    10'd0,    0);
        issue(CMD_ALLOC, 11'd2047, 10'd0,    1);
        issue(CMD_ALLOC, 11'd1025, 10'd1023, 0);
        issue(CMD_FREE,  11'd2047, 10'd1023, 2);
        issue(CMD_FREE,  11'd0,    10'd0,    0);
        issue(CMD_ALLOC, 11'd1024, 10'd0,    0);
        issue(CMD_ALLOC, 11'd1,    10'd0,    3);
        issue(CMD_FREE,  11'd0,    10'd0,    0);
        issue(CMD_ALLOC, 11'd100,  10'd0,    0);
        issue(CMD_ALLOC, 11'd924,  10'd0,    1);
        issue(CMD_FREE,  11'd0,    10'd0,    0);
        issue(CMD_ALLOC, 11'd50,   10'd0,    0);
        issue(CMD_FREE,  11'd0,    10'd100,  0);
        repeat (14)
            issue(CMD_ALLOC, 11'd3, 10'd0, $urandom_range(0, 2));
        issue(CMD_ALLOC, 11'd11, 10'd0, 0);

        // Random: stretches with back-to-back requests between stretches with gaps.
        busy_phase = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                busy_phase = $urandom_range(0, 2);
            random_request(busy_phase == 0 ? 0 : $urandom_range(0, 15));
        end

        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/ffsa_pkg.sv
hdl/ffsa_cell.sv
hdl/first_fit_segment_allocator_top.sv
bench/alloc_result_check.sv
bench/testbench.sv
